// ===== rtl/kst_pkg.sv =====
// Package for the k-smallest tracker: request and response structs,
// action and status codes, and the controller state type.
// No dependencies.
package kst_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_FEW       = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [8:0]         stored_count;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CMP,
    S_RM_RD,
    S_RM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_KTH_RD,
    S_KTH_OUT,
    S_REP_RD,
    S_REP_OUT
  } state_t;

endpackage

// ===== rtl/kst_mem.sv =====
// Element store of the k-smallest tracker: one write port and one read
// port with registered read data. No package dependencies.
module kst_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [31:0]   wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [31:0]   rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/k_smallest_tracker.sv =====
// k-smallest tracker top level: sequencer over a sorted element memory.
// Add moves larger entries up one slot (skipped when full), remove searches and closes the gap;
// both then return the k-th smallest. Clear and empty report answer straight from idle; report
// sends one element per memory read. The next request is taken in the cycle of the final result,
// and the receiver cannot stall. Each step makes at most one memory access.
// Synchronous reset empties the store and sets k to 1; memory is not cleared.
module k_smallest_tracker #(
  parameter int CAPACITY = 256,
  parameter int MAX_K    = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  kst_pkg::req_t in_req,
  output logic          out_strobe,
  output kst_pkg::rsp_t out_rsp,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;

  kst_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    rep_n_r, rep_n_nxt;
  logic signed [31:0] val_r, val_nxt;
  kst_pkg::status_t st_r, st_nxt;
  logic [6:0]       k_r;
  logic             out_strobe_r, out_strobe_nxt;
  kst_pkg::rsp_t    out_rsp_r, out_rsp_nxt;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic signed [31:0] wr_data, rd_data;

  logic [CMPW-1:0]  eff_k, k_ext, cnt_ext;
  logic             few;
  logic [CW-1:0]    idx_inc;

  kst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A k of zero acts as one; anything above MAX_K acts as MAX_K.
  always_comb begin
    k_ext   = CMPW'(k_r);
    cnt_ext = CMPW'(cnt_r);
    if (k_r == 7'd0) begin
      eff_k = CMPW'(1);
    end else if (k_ext > CMPW'(MAX_K)) begin
      eff_k = CMPW'(MAX_K);
    end else begin
      eff_k = k_ext;
    end
    few     = cnt_ext < eff_k;
    idx_inc = idx_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 7'd1;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kst_pkg::S_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    rep_n_r   <= rep_n_nxt;
    val_r     <= val_nxt;
    st_r      <= st_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    rep_n_nxt      = rep_n_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r[AW-1:0];
    wr_data        = val_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r[AW-1:0];

    case (state_r)
      kst_pkg::S_IDLE: begin
        if (start) begin
          val_nxt = in_req.value;
          case (kst_pkg::action_t'(in_req.action))
            kst_pkg::ACT_ADD: begin
              if (cnt_r == CW'(CAPACITY)) begin
                st_nxt    = kst_pkg::ST_FULL;
                state_nxt = kst_pkg::S_KTH_RD;
              end else begin
                st_nxt    = kst_pkg::ST_OK;
                idx_nxt   = cnt_r;
                state_nxt = kst_pkg::S_ADD_RD;
              end
            end
            kst_pkg::ACT_REMOVE: begin
              idx_nxt   = '0;
              state_nxt = kst_pkg::S_RM_RD;
            end
            kst_pkg::ACT_REPORT: begin
              if (cnt_r == '0) begin
                out_strobe_nxt           = 1'b1;
                out_rsp_nxt.result_value = '0;
                out_rsp_nxt.stored_count = '0;
                out_rsp_nxt.status       = kst_pkg::ST_FEW;
                out_rsp_nxt.last         = 1'b1;
              end else begin
                idx_nxt   = '0;
                rep_n_nxt = few ? cnt_r : CW'(eff_k);
                st_nxt    = few ? kst_pkg::ST_FEW : kst_pkg::ST_OK;
                state_nxt = kst_pkg::S_REP_RD;
              end
            end
            kst_pkg::ACT_CLEAR: begin
              cnt_nxt                  = '0;
              out_strobe_nxt           = 1'b1;
              out_rsp_nxt.result_value = '0;
              out_rsp_nxt.stored_count = '0;
              out_rsp_nxt.status       = kst_pkg::ST_FEW;
              out_rsp_nxt.last         = 1'b1;
            end
            default: begin
              state_nxt = kst_pkg::S_IDLE;
            end
          endcase
        end
      end

      // Walk down from the top, moving larger entries up one slot.
      kst_pkg::S_ADD_RD: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = kst_pkg::S_KTH_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(idx_r - CW'(1));
          state_nxt = kst_pkg::S_ADD_CMP;
        end
      end

      kst_pkg::S_ADD_CMP: begin
        wr_en = 1'b1;
        if (rd_data > val_r) begin
          wr_data   = rd_data;
          idx_nxt   = idx_r - CW'(1);
          state_nxt = kst_pkg::S_ADD_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = kst_pkg::S_KTH_RD;
        end
      end

      // Search upward for the first matching copy.
      kst_pkg::S_RM_RD: begin
        if (idx_r == cnt_r) begin
          st_nxt    = kst_pkg::ST_NOT_FOUND;
          state_nxt = kst_pkg::S_KTH_RD;
        end else begin
          rd_en     = 1'b1;
          state_nxt = kst_pkg::S_RM_CMP;
        end
      end

      kst_pkg::S_RM_CMP: begin
        if (rd_data == val_r) begin
          st_nxt    = kst_pkg::ST_OK;
          state_nxt = kst_pkg::S_SH_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = kst_pkg::S_RM_RD;
        end
      end

      // Close the gap by moving each later entry down one slot.
      kst_pkg::S_SH_RD: begin
        if (idx_inc >= cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = kst_pkg::S_KTH_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_inc[AW-1:0];
          state_nxt = kst_pkg::S_SH_WR;
        end
      end

      kst_pkg::S_SH_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        idx_nxt   = idx_inc;
        state_nxt = kst_pkg::S_SH_RD;
      end

      kst_pkg::S_KTH_RD: begin
        rd_en     = !few;
        rd_addr   = AW'(eff_k - CMPW'(1));
        state_nxt = kst_pkg::S_KTH_OUT;
      end

      kst_pkg::S_KTH_OUT: begin
        out_strobe_nxt           = 1'b1;
        out_rsp_nxt.result_value = few ? 32'sd0 : rd_data;
        out_rsp_nxt.stored_count = 9'(cnt_r);
        out_rsp_nxt.status       = (few && st_r == kst_pkg::ST_OK) ? kst_pkg::ST_FEW : st_r;
        out_rsp_nxt.last         = 1'b1;
        state_nxt                = kst_pkg::S_IDLE;
      end

      kst_pkg::S_REP_RD: begin
        rd_en     = 1'b1;
        state_nxt = kst_pkg::S_REP_OUT;
      end

      kst_pkg::S_REP_OUT: begin
        out_strobe_nxt           = 1'b1;
        out_rsp_nxt.result_value = rd_data;
        out_rsp_nxt.stored_count = 9'(cnt_r);
        out_rsp_nxt.status       = st_r;
        out_rsp_nxt.last         = (idx_inc == rep_n_r);
        if (idx_inc == rep_n_r) begin
          state_nxt = kst_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = kst_pkg::S_REP_RD;
        end
      end

      default: begin
        state_nxt = kst_pkg::S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != kst_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> busy)
    else $error("memory written while idle");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_nxt |-> (state_r == kst_pkg::S_IDLE || state_r == kst_pkg::S_KTH_OUT ||
                        state_r == kst_pkg::S_REP_OUT))
    else $error("result issued from a working state");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.action == kst_pkg::ACT_CLEAR) |=>
      (cnt_r == '0 && out_strobe && out_rsp.last))
    else $error("clear did not empty the store");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.last) |-> !busy)
    else $error("final result while still working");
`endif

endmodule
